// ===== rtl/core/hnp_pkg.sv =====
package hnp_pkg;

  // default sizes of the stores
  localparam int MAX_PROTOS_DEF = 1024;
  localparam int MAX_WORDS_DEF  = 16;
  localparam int CLASS_BITS_DEF = 16;

  // port field widths
  localparam int WORD_W     = 64;
  localparam int SLOT_W     = 10;
  localparam int WSLOT_W    = 4;
  localparam int LABEL_W    = 16;
  localparam int DIST_OUT_W = 11;
  localparam int PCNT_W     = 11;
  localparam int WPV_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int POP_W      = 7;

  localparam logic [LABEL_W-1:0] LABEL_OUT_MASK = 16'hffff;
  localparam logic [WPV_W-1:0]   WPV_RESET      = 5'd16;

  // register indices
  localparam logic [CFG_IDX_W-1:0] CFG_PROTO_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORDS_PER_VEC = 1'b1;

  // item functions
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN_A,
    ST_DRAIN_B,
    ST_CLASS,
    ST_REPORT,
    ST_EMPTY
  } hnp_state_t;

  // per-beat control from the sequencer to the distance unit
  typedef struct packed {
    logic clr;
    logic vld;
    logic first;
    logic last_w;
  } hnp_ctl_t;

  // result register control
  typedef struct packed {
    logic load;
    logic empty;
  } hnp_rpt_t;

  // population count, bit-slice adder tree
  function automatic logic [POP_W-1:0] popcount64(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [POP_W-1:0]  s;
    a = x - ((x >> 1) & 64'h5555_5555_5555_5555);
    b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
    c = (b + (b >> 4)) & 64'h0f0f_0f0f_0f0f_0f0f;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + POP_W'(c[8*i +: 8]);
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/hnp_ram.sv =====
module hnp_ram
  import hnp_pkg::*;
#(
  parameter int WIDTH  = WORD_W,
  parameter int DEPTH  = MAX_PROTOS_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/hnp_dist.sv =====
module hnp_dist
  import hnp_pkg::*;
#(
  parameter int PIW    = $clog2(MAX_PROTOS_DEF),
  parameter int DIST_W = $clog2(MAX_WORDS_DEF * WORD_W + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hnp_ctl_t          ctl,
  input  logic [WORD_W-1:0] proto_word,
  input  logic [WORD_W-1:0] query_word,
  output logic [PIW-1:0]    best_p,
  output logic [DIST_W-1:0] best_d
);

  hnp_ctl_t          c1_r;
  hnp_ctl_t          c2_r;
  logic [POP_W-1:0]  pc_r;
  logic [DIST_W-1:0] acc_r;
  logic [DIST_W-1:0] acc_nxt;
  logic [DIST_W-1:0] best_d_r;
  logic [PIW-1:0]    best_p_r;
  logic [PIW-1:0]    cur_p_r;
  logic              has_best_r;
  logic              take;

  // stage 1 lines up with ram read data, stage 2 with the popcount
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
    end else begin
      c1_r <= ctl;
      c2_r <= c1_r;
    end
  end

  always_ff @(posedge clk) begin
    pc_r <= popcount64(proto_word ^ query_word);
  end

  always_comb begin
    acc_nxt = (c2_r.first ? '0 : acc_r) + DIST_W'(pc_r);
    take    = c2_r.vld && c2_r.last_w && (!has_best_r || (acc_nxt < best_d_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_p_r    <= '0;
      has_best_r <= 1'b0;
    end else if (ctl.clr) begin
      cur_p_r    <= '0;
      has_best_r <= 1'b0;
    end else if (c2_r.vld && c2_r.last_w) begin
      cur_p_r    <= cur_p_r + PIW'(1);
      has_best_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (c2_r.vld) begin
      acc_r <= acc_nxt;
    end
    if (take) begin
      best_d_r <= acc_nxt;
      best_p_r <= cur_p_r;
    end
  end

  assign best_p = best_p_r;
  assign best_d = best_d_r;

endmodule

// ===== rtl/core/hnp_seq.sv =====
module hnp_seq
  import hnp_pkg::*;
#(
  parameter int MAX_WORDS = MAX_WORDS_DEF,
  parameter int PIW       = $clog2(MAX_PROTOS_DEF),
  parameter int WW        = $clog2(MAX_WORDS_DEF),
  parameter int PAW       = $clog2(MAX_PROTOS_DEF * MAX_WORDS_DEF)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           go,
  input  logic           cnt_zero,
  input  logic [PIW-1:0] cnt_m1,
  input  logic [WW-1:0]  nw_m1,
  output logic           busy,
  output hnp_ctl_t       ctl,
  output logic [PAW-1:0] proto_raddr,
  output logic [WW-1:0]  query_raddr,
  output hnp_rpt_t       rpt
);

  hnp_state_t     state_r;
  hnp_state_t     state_nxt;
  logic [PIW-1:0] p_r;
  logic [PIW-1:0] p_nxt;
  logic [WW-1:0]  w_r;
  logic [WW-1:0]  w_nxt;
  logic [PAW-1:0] base_r;
  logic [PAW-1:0] base_nxt;
  logic           last_w;
  logic           last_p;

  assign last_w = (w_r == nw_m1);
  assign last_p = (p_r == cnt_m1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (go) begin
          state_nxt = cnt_zero ? ST_EMPTY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_w && last_p) begin
          state_nxt = ST_DRAIN_A;
        end
      end
      ST_DRAIN_A: state_nxt = ST_DRAIN_B;
      ST_DRAIN_B: state_nxt = ST_CLASS;
      ST_CLASS:   state_nxt = ST_REPORT;
      ST_REPORT:  state_nxt = ST_IDLE;
      ST_EMPTY:   state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // word and prototype walk
  always_comb begin
    p_nxt    = p_r;
    w_nxt    = w_r;
    base_nxt = base_r;
    if (state_r == ST_IDLE && go) begin
      p_nxt    = '0;
      w_nxt    = '0;
      base_nxt = '0;
    end else if (state_r == ST_SCAN) begin
      if (last_w) begin
        w_nxt    = '0;
        p_nxt    = p_r + PIW'(1);
        base_nxt = base_r + PAW'(MAX_WORDS);
      end else begin
        w_nxt = w_r + WW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      p_r     <= '0;
      w_r     <= '0;
      base_r  <= '0;
    end else begin
      state_r <= state_nxt;
      p_r     <= p_nxt;
      w_r     <= w_nxt;
      base_r  <= base_nxt;
    end
  end

  // outputs
  always_comb begin
    busy        = (state_r != ST_IDLE);
    ctl.clr     = (state_r == ST_IDLE) && go;
    ctl.vld     = (state_r == ST_SCAN);
    ctl.first   = (w_r == '0);
    ctl.last_w  = last_w;
    proto_raddr = base_r + PAW'(w_r);
    query_raddr = w_r;
    rpt.load    = (state_r == ST_REPORT) || (state_r == ST_EMPTY);
    rpt.empty   = (state_r == ST_EMPTY);
  end

endmodule

// ===== rtl/core/hamming_nearest_prototype_top.sv =====
// binary prototype nearest-neighbour search by hamming distance
//
// input channel: an item is taken at a clock edge where start is high and
// busy is low. in_func selects a prototype word load or a query word write.
// a load gives no result. a query word with in_last set also starts the
// search once its word is written.
// config port: cfg_we writes cfg_wdata into register cfg_index at once
// (0 prototype count, 1 words per vector). the user must see that they are
// only written while busy is low; the block does not enforce this.
// search: one shared xor/popcount/accumulate/compare unit walks the
// prototype store one 64-bit word a cycle; out_valid rises as busy falls
// and is high for one cycle. with no prototypes the result carries
// out_empty_store. busy stays high during the whole search.
// results: each transaction is shown for exactly one cycle on the out_
// ports; the receiver cannot hold them off and must take them then.
// reset: rst_n is synchronous; it clears the sequencer, the config
// registers (count 0, 16 words) and the result strobe. the stores are not
// cleared and must be written before a search reads them.
module hamming_nearest_prototype_top
  import hnp_pkg::*;
#(
  parameter int MAX_PROTOS = MAX_PROTOS_DEF,
  parameter int MAX_WORDS  = MAX_WORDS_DEF,
  parameter int CLASS_BITS = CLASS_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_func,
  input  logic [SLOT_W-1:0]     in_proto_slot,
  input  logic [WSLOT_W-1:0]    in_word_slot,
  input  logic [WORD_W-1:0]     in_data_word,
  input  logic [LABEL_W-1:0]    in_class_label,
  input  logic                  in_last,
  // result channel
  output logic                  out_valid,
  output logic [SLOT_W-1:0]     out_nearest_slot,
  output logic [LABEL_W-1:0]    out_nearest_class,
  output logic [DIST_OUT_W-1:0] out_nearest_distance,
  output logic                  out_empty_store,
  // config port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PIW    = (MAX_PROTOS > 1) ? $clog2(MAX_PROTOS) : 1;
  localparam int WW     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int PDEPTH = MAX_PROTOS * MAX_WORDS;
  localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int DIST_W = $clog2(MAX_WORDS * WORD_W + 1);

  // config registers
  logic [PCNT_W-1:0] proto_count_r;
  logic [WPV_W-1:0]  wpv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proto_count_r <= '0;
      wpv_r         <= WPV_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROTO_COUNT:   proto_count_r <= cfg_wdata[PCNT_W-1:0];
        CFG_WORDS_PER_VEC: wpv_r         <= cfg_wdata[WPV_W-1:0];
        default: ;
      endcase
    end
  end

  // effective count and word count, saturated to the store sizes; a zero word count is taken as one
  logic [31:0]    cnt_sat;
  logic [31:0]    nw_sat;
  logic           cnt_zero;
  logic [PIW-1:0] cnt_m1;
  logic [WW-1:0]  nw_m1;

  always_comb begin
    cnt_sat = (32'(proto_count_r) > 32'(MAX_PROTOS)) ? 32'(MAX_PROTOS)
                                                     : 32'(proto_count_r);
    if (wpv_r == '0) begin
      nw_sat = 32'd1;
    end else if (32'(wpv_r) > 32'(MAX_WORDS)) begin
      nw_sat = 32'(MAX_WORDS);
    end else begin
      nw_sat = 32'(wpv_r);
    end
    cnt_zero = (proto_count_r == '0);
    cnt_m1   = PIW'(cnt_sat - 32'd1);
    nw_m1    = WW'(nw_sat - 32'd1);
  end

  // input transaction decode; out-of-range slots write nothing
  logic              in_fire;
  logic              go;
  logic              pslot_ok;
  logic              wslot_ok;
  logic              proto_we;
  logic              class_we;
  logic              query_we;
  logic [31:0]       pw_addr32;
  logic [31:0]       label32;
  logic [PAW-1:0]    proto_waddr;
  logic [PIW-1:0]    class_waddr;
  logic [WW-1:0]     query_waddr;

  always_comb begin
    in_fire     = start && !busy;
    pslot_ok    = 32'(in_proto_slot) < 32'(MAX_PROTOS);
    wslot_ok    = 32'(in_word_slot) < 32'(MAX_WORDS);
    proto_we    = in_fire && (in_func == FUNC_LOAD) && pslot_ok && wslot_ok;
    class_we    = proto_we && (in_word_slot == '0);
    query_we    = in_fire && (in_func == FUNC_QUERY) && wslot_ok;
    go          = in_fire && (in_func == FUNC_QUERY) && in_last;
    pw_addr32   = 32'(in_proto_slot) * 32'(MAX_WORDS) + 32'(in_word_slot);
    proto_waddr = PAW'(pw_addr32);
    class_waddr = PIW'(32'(in_proto_slot));
    query_waddr = WW'(32'(in_word_slot));
    label32     = 32'(in_class_label);
  end

  // sequencer
  hnp_ctl_t       ctl;
  hnp_rpt_t       rpt;
  logic [PAW-1:0] proto_raddr;
  logic [WW-1:0]  query_raddr;

  hnp_seq #(
    .MAX_WORDS (MAX_WORDS),
    .PIW       (PIW),
    .WW        (WW),
    .PAW       (PAW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (go),
    .cnt_zero    (cnt_zero),
    .cnt_m1      (cnt_m1),
    .nw_m1       (nw_m1),
    .busy        (busy),
    .ctl         (ctl),
    .proto_raddr (proto_raddr),
    .query_raddr (query_raddr),
    .rpt         (rpt)
  );

  // stores
  logic [WORD_W-1:0]     proto_rdata;
  logic [WORD_W-1:0]     query_rdata;
  logic [CLASS_BITS-1:0] class_rdata;
  logic [PIW-1:0]        best_p;
  logic [DIST_W-1:0]     best_d;

  hnp_ram #(
    .WIDTH  (WORD_W),
    .DEPTH  (PDEPTH),
    .ADDR_W (PAW)
  ) u_proto_ram (
    .clk   (clk),
    .we    (proto_we),
    .waddr (proto_waddr),
    .wdata (in_data_word),
    .raddr (proto_raddr),
    .rdata (proto_rdata)
  );

  // class label is read at the current best; settled before the report
  hnp_ram #(
    .WIDTH  (CLASS_BITS),
    .DEPTH  (MAX_PROTOS),
    .ADDR_W (PIW)
  ) u_class_ram (
    .clk   (clk),
    .we    (class_we),
    .waddr (class_waddr),
    .wdata (label32[CLASS_BITS-1:0]),
    .raddr (best_p),
    .rdata (class_rdata)
  );

  hnp_ram #(
    .WIDTH  (WORD_W),
    .DEPTH  (MAX_WORDS),
    .ADDR_W (WW)
  ) u_query_ram (
    .clk   (clk),
    .we    (query_we),
    .waddr (query_waddr),
    .wdata (in_data_word),
    .raddr (query_raddr),
    .rdata (query_rdata)
  );

  // shared distance unit: xor, popcount, accumulate, keep the first minimum
  hnp_dist #(
    .PIW    (PIW),
    .DIST_W (DIST_W)
  ) u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .proto_word (proto_rdata),
    .query_word (query_rdata),
    .best_p     (best_p),
    .best_d     (best_d)
  );

  // result register
  logic                  out_valid_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [LABEL_W-1:0]    out_class_r;
  logic [DIST_OUT_W-1:0] out_dist_r;
  logic                  out_empty_r;
  logic [31:0]           best_p32;
  logic [31:0]           best_d32;
  logic [31:0]           class32;

  always_comb begin
    best_p32 = 32'(best_p);
    best_d32 = 32'(best_d);
    class32  = 32'(class_rdata);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rpt.load;
    end
  end

  always_ff @(posedge clk) begin
    if (rpt.load) begin
      if (rpt.empty) begin
        out_slot_r  <= '0;
        out_class_r <= '0;
        out_dist_r  <= '0;
        out_empty_r <= 1'b1;
      end else begin
        out_slot_r  <= best_p32[SLOT_W-1:0];
        out_class_r <= class32[LABEL_W-1:0] & LABEL_OUT_MASK;
        out_dist_r  <= best_d32[DIST_OUT_W-1:0];
        out_empty_r <= 1'b0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_nearest_slot     = out_slot_r;
  assign out_nearest_class    = out_class_r;
  assign out_nearest_distance = out_dist_r;
  assign out_empty_store      = out_empty_r;

  // one result per search, never two in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // the empty result carries zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_store) |->
      (out_nearest_slot == '0 && out_nearest_class == '0 &&
       out_nearest_distance == '0))
    else $error("empty result with non-zero fields");

  // a last query word always starts a search
  a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FUNC_QUERY && in_last) |=> busy)
    else $error("last query word did not start a search");

  // a found prototype is reported only at the end of a search
  a_report_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_empty_store) |-> $past(busy))
    else $error("result not preceded by a search");

endmodule

// ===== tb/tb_hamming_nearest_prototype_top.sv =====
`timescale 1ns / 100ps

module tb_hamming_nearest_prototype_top;
  import hnp_pkg::*;

  localparam int NPROTO      = MAX_PROTOS_DEF;
  localparam int NWORD       = MAX_WORDS_DEF;
  // allow well over the length of a search of the whole store
  localparam int STALL_LIMIT = 40000;

  // one input transaction as the block sees it
  typedef struct {
    logic                func;
    logic [SLOT_W-1:0]   proto_slot;
    logic [WSLOT_W-1:0]  word_slot;
    logic [WORD_W-1:0]   data_word;
    logic [LABEL_W-1:0]  class_label;
    logic                last;
  } hnp_item_t;

  // one search outcome
  typedef struct {
    logic [SLOT_W-1:0]     slot;
    logic [LABEL_W-1:0]    label;
    logic [DIST_OUT_W-1:0] distance;
    logic                  empty;
  } nearest_t;

  // mirror of the stores and registers, plus the searches still owed by the block
  class nearest_check;
    bit [WORD_W-1:0]     proto_words [NPROTO][NWORD];
    bit [LABEL_W-1:0]    labels [NPROTO];
    bit [WORD_W-1:0]     query_words [NWORD];
    logic [PCNT_W-1:0]   count_reg;
    logic [WPV_W-1:0]    wpv_reg;
    nearest_t            pending_nearest [$];
    int                  errors;

    function new();
      count_reg = '0;
      wpv_reg   = WPV_RESET;
      errors    = 0;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_PROTO_COUNT) begin
        count_reg = data[PCNT_W-1:0];
      end else if (idx == CFG_WORDS_PER_VEC) begin
        wpv_reg = data[WPV_W-1:0];
      end
    endfunction

    function nearest_t find_nearest();
      int unsigned n_protos;
      int unsigned n_words;
      int unsigned d;
      int unsigned best_d;
      int unsigned best_p;
      nearest_t    r;
      n_protos = (count_reg > NPROTO) ? NPROTO : count_reg;
      n_words  = (wpv_reg == 0) ? 1 : (wpv_reg > NWORD) ? NWORD : wpv_reg;
      r.slot     = '0;
      r.label    = '0;
      r.distance = '0;
      r.empty    = 1'b0;
      if (n_protos == 0) begin
        r.empty = 1'b1;
        return r;
      end
      best_d = 0;
      best_p = 0;
      for (int p = 0; p < n_protos; p++) begin
        d = 0;
        for (int w = 0; w < n_words; w++) begin
          d += $countones(proto_words[p][w] ^ query_words[w]);
        end
        if (p == 0 || d < best_d) begin
          best_d = d;
          best_p = p;
        end
      end
      r.slot     = SLOT_W'(best_p);
      r.label    = labels[best_p] & LABEL_OUT_MASK;
      r.distance = DIST_OUT_W'(best_d);
      return r;
    endfunction

    function void note_item(hnp_item_t it);
      if (it.func == FUNC_LOAD) begin
        proto_words[it.proto_slot][it.word_slot] = it.data_word;
        if (it.word_slot == 0) labels[it.proto_slot] = it.class_label;
      end else begin
        query_words[it.word_slot] = it.data_word;
        if (it.last) pending_nearest.push_back(find_nearest());
      end
    endfunction

    task report_mismatch(string msg);
      if (errors < 50) $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(nearest_t got);
      nearest_t want;
      if (pending_nearest.size() == 0) begin
        report_mismatch("result with no search pending");
        return;
      end
      want = pending_nearest.pop_front();
      if (got.slot !== want.slot)
        report_mismatch($sformatf("slot got %0d want %0d", got.slot, want.slot));
      if (got.label !== want.label)
        report_mismatch($sformatf("class got %h want %h", got.label, want.label));
      if (got.distance !== want.distance)
        report_mismatch($sformatf("distance got %0d want %0d", got.distance,
                                  want.distance));
      if (got.empty !== want.empty)
        report_mismatch($sformatf("empty got %b want %b", got.empty, want.empty));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_func = FUNC_LOAD;
  logic [SLOT_W-1:0]     in_proto_slot = '0;
  logic [WSLOT_W-1:0]    in_word_slot = '0;
  logic [WORD_W-1:0]     in_data_word = '0;
  logic [LABEL_W-1:0]    in_class_label = '0;
  logic                  in_last = 1'b0;
  logic                  out_valid;
  logic [SLOT_W-1:0]     out_nearest_slot;
  logic [LABEL_W-1:0]    out_nearest_class;
  logic [DIST_OUT_W-1:0] out_nearest_distance;
  logic                  out_empty_store;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_PROTO_COUNT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  nearest_check chk = new();

  // which store entries hold a value, so that no search ever reads an unwritten one
  bit proto_wr [NPROTO][NWORD];
  bit query_wr [NWORD];
  // sender gaps on or off for the current phase
  bit idle_on = 1'b1;
  int unsigned items_sent = 0;
  int stall_cycles = 0;

  hamming_nearest_prototype_top u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_func              (in_func),
    .in_proto_slot        (in_proto_slot),
    .in_word_slot         (in_word_slot),
    .in_data_word         (in_data_word),
    .in_class_label       (in_class_label),
    .in_last              (in_last),
    .out_valid            (out_valid),
    .out_nearest_slot     (out_nearest_slot),
    .out_nearest_class    (out_nearest_class),
    .out_nearest_distance (out_nearest_distance),
    .out_empty_store      (out_empty_store),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: every strobe is a transaction, sampled on the edge that ends its cycle
  always @(posedge clk) begin : result_mon
    nearest_t got;
    if (rst_n && out_valid) begin
      got.slot     = out_nearest_slot;
      got.label    = out_nearest_class;
      got.distance = out_nearest_distance;
      got.empty    = out_empty_store;
      chk.check_result(got);
    end
  end

  // watchdog: cycles in which neither channel moves a transaction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_hamming_nearest_prototype_top: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // a word equal to base, a bit or a few bits off, or unrelated: gives close races and ties
  function automatic logic [WORD_W-1:0] near_word(logic [WORD_W-1:0] base);
    case ($urandom_range(3))
      0: return base;
      1: return base ^ (64'd1 << $urandom_range(63));
      2: return base ^ (rand_word() & rand_word() & rand_word());
      default: return rand_word();
    endcase
  endfunction

  function automatic hnp_item_t pack_item(logic func, int unsigned slot, int unsigned wslot,
                                          logic [WORD_W-1:0] data, int unsigned label,
                                          bit last);
    hnp_item_t it;
    it.func        = func;
    it.proto_slot  = SLOT_W'(slot);
    it.word_slot   = WSLOT_W'(wslot);
    it.data_word   = data;
    it.class_label = LABEL_W'(label);
    it.last        = last;
    return it;
  endfunction

  // drive one transaction and hold it until the block takes it
  task automatic send_item(input hnp_item_t it);
    if (idle_on && $urandom_range(99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start          <= 1'b1;
    in_func        <= it.func;
    in_proto_slot  <= it.proto_slot;
    in_word_slot   <= it.word_slot;
    in_data_word   <= it.data_word;
    in_class_label <= it.class_label;
    in_last        <= it.last;
    @(posedge clk);
    while (busy) @(posedge clk);
    chk.note_item(it);
    items_sent++;
    if (it.func == FUNC_LOAD) proto_wr[it.proto_slot][it.word_slot] = 1'b1;
    else query_wr[it.word_slot] = 1'b1;
  endtask

  // let every owed result arrive and the block fall idle
  task automatic settle();
    start <= 1'b0;
    while (chk.pending_nearest.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_DATA_W-1:0] count,
                            input logic [CFG_DATA_W-1:0] wpv);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PROTO_COUNT;
    cfg_wdata <= count;
    @(posedge clk);
    chk.note_config(CFG_PROTO_COUNT, count);
    cfg_index <= CFG_WORDS_PER_VEC;
    cfg_wdata <= wpv;
    @(posedge clk);
    chk.note_config(CFG_WORDS_PER_VEC, wpv);
    cfg_we <= 1'b0;
  endtask

  // one configuration setting followed by a stretch of random traffic
  task automatic run_phase(input int unsigned count, input int unsigned wpv,
                           input int unsigned n_items);
    int unsigned n_protos;
    int unsigned n_words;
    int unsigned sent;
    int unsigned pick;
    int unsigned target;
    int unsigned p;
    int unsigned w;
    int          order [$];
    logic [WORD_W-1:0] data;
    bit          ready;
    settle();
    write_regs(CFG_DATA_W'(count), CFG_DATA_W'(wpv));
    n_protos = (count > NPROTO) ? NPROTO : count;
    n_words  = (wpv == 0) ? 1 : (wpv > NWORD) ? NWORD : wpv;
    // fill whatever the search will compare and has not been written yet
    for (int i = 0; i < n_protos; i++) begin
      for (int j = 0; j < n_words; j++) begin
        if (!proto_wr[i][j])
          send_item(pack_item(FUNC_LOAD, i, j, rand_word(), $urandom, $urandom_range(1)));
      end
    end
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        // well-formed query: every compared word in random order, last on the final one
        target = (n_protos == 0) ? 0 : $urandom_range(n_protos - 1);
        order.delete();
        for (int j = 0; j < n_words; j++) order.push_back(j);
        order.shuffle();
        for (int j = 0; j < n_words; j++) begin
          data = near_word(chk.proto_words[target][order[j]]);
          send_item(pack_item(FUNC_QUERY, $urandom, order[j], data, $urandom,
                              j == n_words - 1));
        end
        sent += n_words;
      end else if (pick < 75) begin
        // prototype load, mostly into the searched range so results move
        if (n_protos != 0 && $urandom_range(3) != 0) p = $urandom_range(n_protos - 1);
        else p = $urandom_range(NPROTO - 1);
        w = $urandom_range(NWORD - 1);
        case ($urandom_range(2))
          0: data = rand_word();
          1: data = chk.proto_words[$urandom_range(n_protos == 0 ? 0 : n_protos - 1)][w];
          default: data = near_word(chk.query_words[w]);
        endcase
        send_item(pack_item(FUNC_LOAD, p, w, data, $urandom, $urandom_range(1)));
        sent++;
      end else begin
        // stray query word; last only where the whole query is already written
        w = $urandom_range(NWORD - 1);
        ready = 1'b1;
        for (int j = 0; j < n_words; j++) begin
          if (!query_wr[j] && j != w) ready = 1'b0;
        end
        send_item(pack_item(FUNC_QUERY, $urandom, w, near_word(chk.query_words[w]), $urandom,
                            ready && $urandom_range(1)));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int unsigned phase_no;
    int unsigned kind;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty store straight after reset, registers at their reset values
    send_item(pack_item(FUNC_QUERY, NPROTO - 1, NWORD - 1, '1, 16'hffff, 1'b1));
    // last on a load is ignored, no result
    send_item(pack_item(FUNC_LOAD, NPROTO - 1, NWORD - 1, '1, 0, 1'b1));

    // largest distance: all-zero prototype against an all-ones query over every word
    settle();
    write_regs(1, 16);
    for (int j = 0; j < NWORD; j++) send_item(pack_item(FUNC_LOAD, 0, j, '0, 16'hffff, 1'b0));
    for (int j = 0; j < NWORD; j++)
      send_item(pack_item(FUNC_QUERY, 0, j, '1, 0, j == NWORD - 1));

    // word count above the store size saturates; second prototype matches exactly
    settle();
    write_regs(2, 31);
    for (int j = 0; j < NWORD; j++) send_item(pack_item(FUNC_LOAD, 1, j, '1, 0, 1'b0));
    send_item(pack_item(FUNC_QUERY, 0, 0, '1, 0, 1'b1));

    // zero word count taken as one; equal distances go to the lower slot
    settle();
    write_regs(2, 0);
    send_item(pack_item(FUNC_LOAD, 1, 0, '0, 16'h5a5a, 1'b0));
    send_item(pack_item(FUNC_QUERY, 0, 0, 64'h8000_0000_0000_0000, 0, 1'b1));

    // count far above the store size saturates to a full store; a long stretch
    // with no sender gaps
    idle_on = 1'b0;
    run_phase(2047, 0, 100);
    idle_on = 1'b1;
    run_phase(NPROTO, 1, 60);
    run_phase(0, 16, 30);

    phase_no = 0;
    while (items_sent < 1800) begin
      // one phase with no sender gaps at all
      idle_on = (phase_no != 3);
      kind = $urandom_range(99);
      if (kind < 70) run_phase($urandom_range(1, 24), $urandom_range(0, 31),
                               $urandom_range(40, 120));
      else if (kind < 85) run_phase(0, $urandom_range(0, 31), $urandom_range(20, 40));
      else run_phase($urandom_range(1000, 2047), $urandom_range(0, 1), $urandom_range(30, 60));
      phase_no++;
    end

    settle();
    repeat (16) @(posedge clk);
    if (chk.errors == 0) begin
      $display("tb_hamming_nearest_prototype_top: done, clean");
    end else begin
      $display("tb_hamming_nearest_prototype_top: done, errors");
    end
    $finish;
  end

endmodule
